>>> hw/rtl/iprl_pkg.sv
// Shared types and constants for the IP range table lookup block.
// Holds request/result structs, the table entry layout and FSM states; no dependencies.
`default_nettype none

package iprl_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 11;
	// signed search bound: holds -1 up to TABLE_DEPTH
	localparam int PTR_W       = IDX_W + 2;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] entry_index;
		logic [31:0]      entry_start;
		logic [31:0]      entry_end;
		logic [7:0]       entry_length;
		logic [23:0]      entry_offset;
		logic [31:0]      query_address;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [7:0]  data_length;
		logic [23:0] data_offset;
	} res_t;

	typedef struct packed {
		logic [31:0] range_start;
		logic [31:0] range_end;
		logic [7:0]  data_length;
		logic [23:0] data_offset;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ip_range_table_lookup_top.sv
// Top level of the IP range table lookup: command handshake, search sequencer, result register.
// Depends on iprl_pkg and iprl_table.
`default_nettype none

// Range table lookup. A request is taken at a clock edge where start is high and busy is
// low. A load request (kind = 0) writes one table entry in that same edge and leaves busy
// low, so loads can be issued every cycle while no lookup is running. A lookup request
// raises busy and binary-searches the first entry_count entries (saturated to the table
// depth) for a range holding query_address. Each probe passes through a PROBE state that
// issues the table read and a COMPARE state that compares against the registered read data,
// since the whole search runs through the single read port of the table memory. A lookup
// makes at most eleven probes for 1024 entries; an empty table ends it in the first PROBE
// state with no table read. The result
// appears on result for exactly one cycle, marked by done; nothing can stall it, so the
// receiver must capture it then. busy drops in the done cycle and the next request may be
// taken there. Not-found results carry zero length and offset. Write entry_count only while
// busy is low. Entries must be loaded before a lookup can probe them; the table has no reset.
module ip_range_table_lookup_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire iprl_pkg::req_t            request,
	input  wire logic                      cfg_we,
	input  wire logic [iprl_pkg::CNT_W-1:0] cfg_data,
	output logic                           done,
	output iprl_pkg::res_t                 result
);
	import iprl_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_eff;
	logic signed [PTR_W-1:0] lo_q, hi_q;
	logic signed [PTR_W-1:0] ptr_sum;
	logic [IDX_W-1:0]        mid;
	logic [IDX_W-1:0]        mid_q;
	logic [31:0]             query_q;

	logic   accept, load_req, lookup_req;
	logic   in_range, below, above, hit;
	logic   rd_en;
	entry_t wr_entry, rd_entry;

	res_t   result_q;
	logic   done_q;

	assign accept     = start & ~busy;
	assign load_req   = accept & (request.kind == KIND_LOAD);
	assign lookup_req = accept & (request.kind == KIND_LOOKUP);

	// Saturate the programmed count at the table depth.
	assign count_eff = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;

	// Midpoint of [lo, hi]; both are non-negative whenever a probe is issued.
	assign in_range = (lo_q <= hi_q);
	assign ptr_sum  = lo_q + hi_q;
	assign mid      = ptr_sum[IDX_W:1];

	assign below = (query_q < rd_entry.range_start);
	assign above = (query_q > rd_entry.range_end);
	assign hit   = ~below & ~above;

	assign wr_entry = '{
		range_start: request.entry_start,
		range_end:   request.entry_end,
		data_length: request.entry_length,
		data_offset: request.entry_offset
	};

	// Loads only land while idle and reads only issue while busy, so the ports never collide.
	iprl_table u_table (
		.clk     (clk),
		.wr_en   (load_req),
		.wr_addr (request.entry_index),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (mid),
		.rd_data (rd_entry)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (lookup_req) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (in_range) begin
					state_d = ST_COMPARE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_COMPARE: begin
				if (hit) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PROBE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		unique case (state_q)
			ST_IDLE:    busy  = 1'b0;
			ST_PROBE:   rd_en = in_range;
			ST_COMPARE: rd_en = 1'b0;
			default:    busy  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			// Strobe a result when the search window empties or a probe hits.
			done_q <= ((state_q == ST_PROBE) && !in_range) ||
			          ((state_q == ST_COMPARE) && hit);
		end
	end

	// Search bounds and result payload.
	always_ff @(posedge clk) begin
		if (lookup_req) begin
			query_q <= request.query_address;
			lo_q    <= '0;
			hi_q    <= PTR_W'(count_eff) - PTR_W'(1);
		end
		if (state_q == ST_PROBE) begin
			mid_q <= mid;
			if (!in_range) begin
				result_q <= '0;
			end
		end
		if (state_q == ST_COMPARE) begin
			if (below) begin
				hi_q <= PTR_W'(mid_q) - PTR_W'(1);
			end else if (above) begin
				lo_q <= PTR_W'(mid_q) + PTR_W'(1);
			end else begin
				result_q <= '{
					found:       1'b1,
					data_length: rd_entry.data_length,
					data_offset: rd_entry.data_offset
				};
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result is only strobed once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobed while search still running");

	// A miss carries an all-zero payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.data_length == 8'd0 && result.data_offset == 24'd0))
		else $error("not-found result with nonzero payload");

	// An accepted lookup always occupies the sequencer on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == KIND_LOOKUP) |=> busy)
		else $error("lookup accepted without starting a search");

	// Loads never start a search.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == KIND_LOAD) |=> !busy)
		else $error("load request raised busy");

	// A compare always follows a probe that issued a read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> $past(rd_en))
		else $error("compare without a preceding table read");

endmodule

`default_nettype wire

>>> hw/rtl/iprl_table.sv
// Range table storage: one synchronous memory of entries, one write and one read port.
// Depends on iprl_pkg for the entry layout and table depth.
`default_nettype none

module iprl_table (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [iprl_pkg::IDX_W-1:0] wr_addr,
	input  wire iprl_pkg::entry_t          wr_data,
	input  wire logic                      rd_en,
	input  wire logic [iprl_pkg::IDX_W-1:0] rd_addr,
	output iprl_pkg::entry_t               rd_data
);
	import iprl_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data registered: valid in the cycle after rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
